// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the odometry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/owo_pkg.sv =====
// Types, constants and helper functions for the omni wheel odometry block.
package owo_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_HALF_RADIUS = 2'd0;
  localparam logic [1:0] REG_YAW_GAIN    = 2'd1;
  localparam logic [1:0] REG_MOUNT_COS   = 2'd2;
  localparam logic [1:0] REG_MOUNT_SIN   = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] HALF_RADIUS_RST = 16'd3277;
  localparam logic [15:0] YAW_GAIN_RST    = 16'd4096;
  localparam logic [15:0] MOUNT_COS_RST   = 16'd11585;
  localparam logic [15:0] MOUNT_SIN_RST   = 16'hD2BF;

  // Depth of the queue between the twist stage and the pose stage.
  localparam int QUEUE_DEPTH = 2;

  // Longest arctangent table available to the rotator.
  localparam int ATAN_LEN = 24;

  // Reciprocal CORDIC gain, signed Q1.16.
  localparam logic signed [17:0] INV_GAIN = 18'sd39797;

  // Binary-angle turns per radian, 2^32 / (2 pi).
  localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;

  // One twist transaction handed from the front stage to the back stage.
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic [15:0]        dt;
  } owo_item_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2F9;
      5'd15:   val = 32'h0000517C;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A2F;
      5'd19:   val = 32'h00000517;
      5'd20:   val = 32'h0000028B;
      5'd21:   val = 32'h00000145;
      5'd22:   val = 32'h000000A2;
      5'd23:   val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [63:0] val);
    logic signed [15:0] res;
    if (val > 64'sd32767) begin
      res = 16'sh7FFF;
    end else if (val < -64'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = val[15:0];
    end
    return res;
  endfunction

  // Saturate a 33-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] val);
    logic signed [31:0] res;
    if (val[32] != val[31]) begin
      res = val[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/owo_fifo.sv =====
// Small register queue between the twist stage and the pose stage.
`include "assert_macros.svh"

module owo_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty)

endmodule

// ===== rtl/owo_front.sv =====
// Front stage: configuration registers and body twist from the wheel speeds.
`include "assert_macros.svh"

module owo_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  front_left_speed,
  input  logic signed [15:0]  rear_left_speed,
  input  logic signed [15:0]  rear_right_speed,
  input  logic signed [15:0]  front_right_speed,
  input  logic [15:0]         step_time,
  output logic                push,
  output owo_pkg::owo_item_t  item,
  input  logic                full
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t            state;
  logic [2:0]         step;
  logic [15:0]        half_radius;
  logic [15:0]        yaw_gain;
  logic signed [15:0] mount_cos;
  logic signed [15:0] mount_sin;
  logic signed [16:0] sum_13;
  logic signed [16:0] sum_24;
  logic signed [17:0] yaw_sum;
  logic [15:0]        dt;
  logic signed [33:0] u;
  logic signed [33:0] v;
  logic signed [51:0] acc_x;
  logic signed [51:0] acc_y;
  logic signed [34:0] acc_w;

  logic signed [16:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [51:0] prod;
  logic signed [51:0] rnd_x;
  logic signed [51:0] rnd_y;
  logic signed [34:0] rnd_w;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == F_IDLE);
  assign push      = (state == F_PUSH) && !full;

  // Shared multiplier: one product per step of the twist sequence.
  always_comb begin
    case (step)
      3'd0: begin
        mul_a = $signed({1'b0, half_radius});
        mul_b = 35'(sum_13);
      end
      3'd1: begin
        mul_a = $signed({1'b0, half_radius});
        mul_b = 35'(sum_24);
      end
      3'd2: begin
        mul_a = 17'(mount_cos);
        mul_b = 35'(u);
      end
      3'd3: begin
        mul_a = 17'(mount_sin);
        mul_b = 35'(v);
      end
      3'd4: begin
        mul_a = 17'(mount_sin);
        mul_b = 35'(u);
      end
      3'd5: begin
        mul_a = 17'(mount_cos);
        mul_b = 35'(v);
      end
      3'd6: begin
        mul_a = $signed({1'b0, yaw_gain});
        mul_b = 35'(yaw_sum);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Round half up and saturate the twist for the queue.
  always_comb begin
    rnd_x   = (acc_x + (52'sd1 <<< 29)) >>> 30;
    rnd_y   = (acc_y + (52'sd1 <<< 29)) >>> 30;
    rnd_w   = (acc_w + (35'sd1 <<< 13)) >>> 14;
    item.vx = owo_pkg::sat16(64'(rnd_x));
    item.vy = owo_pkg::sat16(64'(rnd_y));
    item.wz = owo_pkg::sat16(64'(rnd_w));
    item.dt = dt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_radius <= owo_pkg::HALF_RADIUS_RST;
      yaw_gain    <= owo_pkg::YAW_GAIN_RST;
      mount_cos   <= owo_pkg::MOUNT_COS_RST;
      mount_sin   <= owo_pkg::MOUNT_SIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        owo_pkg::REG_HALF_RADIUS: half_radius <= cfg_data;
        owo_pkg::REG_YAW_GAIN:    yaw_gain    <= cfg_data;
        owo_pkg::REG_MOUNT_COS:   mount_cos   <= cfg_data;
        owo_pkg::REG_MOUNT_SIN:   mount_sin   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer for the twist products.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_MUL;
            step  <= '0;
          end
        end
        F_MUL: begin
          step <= step + 1'b1;
          if (step == 3'd6) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      sum_13  <= 17'(front_left_speed) + 17'(rear_right_speed);
      sum_24  <= 17'(rear_left_speed) + 17'(front_right_speed);
      yaw_sum <= 18'(rear_right_speed) + 18'(front_right_speed)
               - 18'(front_left_speed) - 18'(rear_left_speed);
      dt      <= step_time;
    end
    if (state == F_MUL) begin
      case (step)
        3'd0:    u     <= prod[33:0];
        3'd1:    v     <= prod[33:0];
        3'd2:    acc_x <= prod;
        3'd3:    acc_x <= acc_x - prod;
        3'd4:    acc_y <= prod;
        3'd5:    acc_y <= acc_y + prod;
        3'd6:    acc_w <= prod[34:0];
        default: ;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLIES(a_push_after_products, clk, rst, push, step == 3'd7)

endmodule

// ===== rtl/owo_back.sv =====
// Back stage: CORDIC rotation by heading and pose integration.
`include "assert_macros.svh"

module owo_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  owo_pkg::owo_item_t  item,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  body_vx,
  output logic signed [15:0]  body_vy,
  output logic signed [15:0]  body_yaw_rate,
  output logic signed [31:0]  pose_x,
  output logic signed [31:0]  pose_y,
  output logic [15:0]         pose_heading
);

  localparam int ROT_STEPS =
    (CORDIC_STEPS < owo_pkg::ATAN_LEN) ? CORDIC_STEPS : owo_pkg::ATAN_LEN;

  typedef enum logic [3:0] {
    B_IDLE, B_ROT, B_GX, B_GY, B_DX, B_DY, B_H1, B_H2, B_DONE
  } bstate_t;

  bstate_t            state;
  logic [4:0]         iter;
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [32:0] z;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [15:0] wz;
  logic [15:0]        dt;
  logic signed [63:0] prod;
  logic signed [35:0] gx;
  logic signed [35:0] gy;
  logic signed [29:0] dx;
  logic signed [29:0] dy;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic [15:0]        heading;

  logic signed [35:0] x_init;
  logic signed [32:0] z_init;
  logic               fold;
  logic signed [35:0] x_sh;
  logic signed [35:0] y_sh;
  logic signed [32:0] atan_val;
  logic signed [32:0] sum_x;
  logic signed [32:0] sum_y;
  logic signed [63:0] head_rnd;
  logic               load;

  assign pop  = (state == B_IDLE) && !empty;
  assign load = (state == B_DONE) && (!out_valid || out_ready);

  // Quadrant fold of the starting angle.
  always_comb begin
    z_init = 33'($signed({heading, 16'h0000}));
    x_init = {{4{item.vx[15]}}, item.vx, 16'h0000};
    fold   = 1'b0;
    if (z_init > 33'sh040000000) begin
      fold   = 1'b1;
      z_init = z_init - 33'sh080000000;
    end else if (z_init < -33'sh040000000) begin
      fold   = 1'b1;
      z_init = z_init + 33'sh080000000;
    end
  end

  // One CORDIC iteration per cycle.
  always_comb begin
    x_sh     = x >>> iter;
    y_sh     = y >>> iter;
    atan_val = $signed({1'b0, owo_pkg::atan_entry(iter)});
  end

  // Pose update from the final products.
  always_comb begin
    sum_x    = 33'(world_x) + 33'(dx);
    sum_y    = 33'(world_y) + 33'(dy);
    head_rnd = prod + (64'sd1 <<< 39);
  end

  // Sequencer for rotation, scaling and integration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      iter  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= B_ROT;
            iter  <= '0;
          end
        end
        B_ROT: begin
          iter <= iter + 1'b1;
          if (iter == 5'(ROT_STEPS - 1)) begin
            state <= B_GX;
          end
        end
        B_GX:   state <= B_GY;
        B_GY:   state <= B_DX;
        B_DX:   state <= B_DY;
        B_DY:   state <= B_H1;
        B_H1:   state <= B_H2;
        B_H2:   state <= B_DONE;
        B_DONE: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) begin
          vx <= item.vx;
          vy <= item.vy;
          wz <= item.wz;
          dt <= item.dt;
          x  <= fold ? -x_init : x_init;
          y  <= fold ? -{{4{item.vy[15]}}, item.vy, 16'h0000}
                     : {{4{item.vy[15]}}, item.vy, 16'h0000};
          z  <= z_init;
        end
      end
      B_ROT: begin
        if (!z[32]) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_val;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_val;
        end
      end
      B_GX: prod <= x * owo_pkg::INV_GAIN;
      B_GY: begin
        gx   <= 36'((prod + 64'sd32768) >>> 16);
        prod <= y * owo_pkg::INV_GAIN;
      end
      B_DX: begin
        gy   <= 36'((prod + 64'sd32768) >>> 16);
        prod <= gx * $signed({1'b0, dt});
      end
      B_DY: begin
        dx   <= 30'((prod + 64'sd8388608) >>> 24);
        prod <= gy * $signed({1'b0, dt});
      end
      B_H1: begin
        dy   <= 30'((prod + 64'sd8388608) >>> 24);
        prod <= wz * $signed({1'b0, dt});
      end
      B_H2: prod <= $signed(prod[33:0]) * owo_pkg::TURN_PER_RAD;
      default: ;
    endcase
  end

  // Pose state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      world_x   <= '0;
      world_y   <= '0;
      heading   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        world_x   <= owo_pkg::sat32(sum_x);
        world_y   <= owo_pkg::sat32(sum_y);
        heading   <= heading + head_rnd[55:40];
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      body_vx       <= vx;
      body_vy       <= vy;
      body_yaw_rate <= wz;
      pose_x        <= owo_pkg::sat32(sum_x);
      pose_y        <= owo_pkg::sat32(sum_y);
      pose_heading  <= heading + head_rnd[55:40];
    end
  end

  `ASSERT_NEXT(a_heading_holds, clk, rst, !load, $stable(heading))
  `ASSERT_NEXT(a_pop_starts_rotation, clk, rst, pop, state == B_ROT && iter == '0)

endmodule

// ===== rtl/omni_wheel_odometry.sv =====
// Top level of the four-wheel omni drive odometry block.
//
// Each input transaction carries four wheel speeds and a time step and yields
// one result transaction: the saturated body twist and the updated world pose.
// The front stage forms the twist with one shared multiplier over seven steps
// and places it in a two-entry queue. The back stage rotates the twist by the
// stored heading with a CORDIC that runs one iteration per cycle, then scales
// and integrates in the states GX, GY, DX, DY, H1 and H2 before DONE; it takes
// no new twist from the queue until it has loaded the last result. The result
// waits in an output register, so the front stage keeps accepting while a
// result is unclaimed, until the queue is full. The user must write
// configuration through the cfg port only while no transaction is in flight;
// the block itself does not enforce this.
module omni_wheel_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] front_left_speed,
  input  logic signed [15:0] rear_left_speed,
  input  logic signed [15:0] rear_right_speed,
  input  logic signed [15:0] front_right_speed,
  input  logic [15:0]        step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] body_vx,
  output logic signed [15:0] body_vy,
  output logic signed [15:0] body_yaw_rate,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [15:0]        pose_heading
);

  localparam int ITEM_W = $bits(owo_pkg::owo_item_t);

  owo_pkg::owo_item_t  front_item;
  owo_pkg::owo_item_t  back_item;
  logic [ITEM_W-1:0]   q_rd_data;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  assign back_item = owo_pkg::owo_item_t'(q_rd_data);

  owo_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .front_left_speed  (front_left_speed),
    .rear_left_speed   (rear_left_speed),
    .rear_right_speed  (rear_right_speed),
    .front_right_speed (front_right_speed),
    .step_time         (step_time),
    .push              (q_push),
    .item              (front_item),
    .full              (q_full)
  );

  owo_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (owo_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (front_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  owo_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (back_item),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .body_vx       (body_vx),
    .body_vy       (body_vy),
    .body_yaw_rate (body_yaw_rate),
    .pose_x        (pose_x),
    .pose_y        (pose_y),
    .pose_heading  (pose_heading)
  );

endmodule
